FILE: hdl/pidsc_pkg.sv
// pidsc_pkg: types, widths and constants shared by the steering pid controller
// no dependencies; compiled first

package pidsc_pkg;

    localparam int TGT_W      = 13;
    localparam int MEAS_W     = 16;
    localparam int ERR_W      = 18;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 8;
    localparam int LIMH_W     = 7;
    localparam int DB_W       = 16;
    localparam int SERVO_W    = 8;
    localparam int INTEG_W    = 8;
    localparam int DMEAS_W    = 17;
    localparam int MAG_W      = 16;
    localparam int PROD_W     = GAIN_W + MAG_W;
    localparam int PRE_SHIFT  = 3;
    localparam int DIVN_W     = PROD_W - PRE_SHIFT;
    localparam int RECIP_W    = 30;
    localparam int DIV_SHIFT  = 36;
    localparam int FULL_W     = DIVN_W + RECIP_W;
    localparam int Q_W        = FULL_W - DIV_SHIFT;
    localparam int ACC_W      = 26;
    localparam int ISUM_W     = ERR_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    // floor(n / 1000) = floor(floor(n / 8) * RECIP / 2^36) for n below 2^32
    localparam logic [RECIP_W-1:0] DIV_RECIP = 30'd549755814;
    localparam logic [SERVO_W-1:0] NEUTRAL_POS = 8'd127;

    localparam logic [GAIN_W-1:0]        RST_PROP_GAIN  = '0;
    localparam logic [GAIN_W-1:0]        RST_INTEG_GAIN = '0;
    localparam logic [GAIN_W-1:0]        RST_DERIV_GAIN = '0;
    localparam logic signed [LIM_W-1:0]  RST_LIMIT_LOW  = -8'sd127;
    localparam logic [LIMH_W-1:0]        RST_LIMIT_HIGH = 7'd127;
    localparam logic [DB_W-1:0]          RST_DEADBAND   = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_INTEG_GAIN = 3'd1,
        CFG_DERIV_GAIN = 3'd2,
        CFG_LIMIT_LOW  = 3'd3,
        CFG_LIMIT_HIGH = 3'd4,
        CFG_DEADBAND   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]       prop_gain;
        logic [GAIN_W-1:0]       integ_gain;
        logic [GAIN_W-1:0]       deriv_gain;
        logic signed [LIM_W-1:0] limit_low;
        logic [LIMH_W-1:0]       limit_high;
        logic [DB_W-1:0]         deadband_sq;
    } t_cfg;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [MEAS_W-1:0] meas;
        logic                     dead;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_MUL,
        ST_DIV,
        ST_ACC,
        ST_OUT
    } t_back_state;

    typedef enum logic [1:0] {
        TERM_P,
        TERM_I,
        TERM_D
    } t_term;

    typedef struct packed {
        logic idle;
        logic in_out;
    } t_back_stat;

endpackage

FILE: hdl/pidsc_if.sv
// pidsc_if: valid/ready channel interfaces for samples, results and config writes
// depends on pidsc_pkg

interface pidsc_sample_if;
    import pidsc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [TGT_W-1:0]  target_angle;
    logic signed [MEAS_W-1:0] measured_angle;
    modport source (output valid, output target_angle, output measured_angle, input ready);
    modport sink   (input valid, input target_angle, input measured_angle, output ready);
endinterface

interface pidsc_result_if;
    import pidsc_pkg::*;
    logic               valid;
    logic               ready;
    logic [SERVO_W-1:0] servo_position;
    logic               in_deadband;
    modport source (output valid, output servo_position, output in_deadband, input ready);
    modport sink   (input valid, input servo_position, input in_deadband, output ready);
endinterface

interface pidsc_cfg_if;
    import pidsc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/pid_steering_controller_core.sv
// pid_steering_controller_core: steering pid loop; the back's shared multiplier serves
// one sample at a time, an active one through update, multiply, divide and accumulate
// per term, a deadband one straight to output; queue of 4 between; synchronous
// active-low reset restores config defaults, zeroes integral and last measurement
// and empties the queue; a config write is taken every cycle
// depends on pidsc_pkg, pidsc_if, pidsc_front, pidsc_fifo, pidsc_back

module pid_steering_controller_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pidsc_sample_if.sink   i_sample,
    pidsc_cfg_if.sink      i_cfg,
    pidsc_result_if.source o_result
);
    import pidsc_pkg::*;

    t_cfg       r_cfg;
    logic       w_fr_valid;
    logic       w_fr_ready;
    t_job       w_fr_job;
    logic       w_job_valid;
    logic       w_job_ready;
    t_job       w_job;
    t_back_stat w_stat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain   <= RST_PROP_GAIN;
            r_cfg.integ_gain  <= RST_INTEG_GAIN;
            r_cfg.deriv_gain  <= RST_DERIV_GAIN;
            r_cfg.limit_low   <= RST_LIMIT_LOW;
            r_cfg.limit_high  <= RST_LIMIT_HIGH;
            r_cfg.deadband_sq <= RST_DEADBAND;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_PROP_GAIN:  r_cfg.prop_gain   <= i_cfg.data[GAIN_W-1:0];
                CFG_INTEG_GAIN: r_cfg.integ_gain  <= i_cfg.data[GAIN_W-1:0];
                CFG_DERIV_GAIN: r_cfg.deriv_gain  <= i_cfg.data[GAIN_W-1:0];
                CFG_LIMIT_LOW:  r_cfg.limit_low   <= $signed(i_cfg.data[LIM_W-1:0]);
                CFG_LIMIT_HIGH: r_cfg.limit_high  <= i_cfg.data[LIMH_W-1:0];
                CFG_DEADBAND:   r_cfg.deadband_sq <= i_cfg.data[DB_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    pidsc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sample      (i_sample),
        .i_deadband_sq (r_cfg.deadband_sq),
        .o_job_valid   (w_fr_valid),
        .i_job_ready   (w_fr_ready),
        .o_job         (w_fr_job)
    );

    pidsc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_ready (w_fr_ready),
        .i_job   (w_fr_job),
        .o_valid (w_job_valid),
        .i_ready (w_job_ready),
        .o_job   (w_job)
    );

    pidsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_job_valid),
        .o_job_ready (w_job_ready),
        .i_job       (w_job),
        .o_result    (o_result),
        .o_stat      (w_stat)
    );

    // deadband results always carry the neutral position
    a_dead_neutral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.in_deadband |-> o_result.servo_position == NEUTRAL_POS)
        else $error("deadband result not neutral");

    // a new result beat only comes out of the output state
    a_out_from_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(w_stat.in_out))
        else $error("result valid without output state");

    // an idle back with a queued job always starts on it
    a_idle_takes_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_valid && w_stat.idle |=> !w_stat.idle)
        else $error("back stayed idle with queued job");

endmodule

FILE: hdl/pidsc_front.sv
// pidsc_front: takes a sample beat, forms the scaled error and flags deadband hits
// depends on pidsc_pkg and pidsc_if

module pidsc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pidsc_sample_if.sink       i_sample,
    input  logic [pidsc_pkg::DB_W-1:0] i_deadband_sq,
    output logic               o_job_valid,
    input  logic               i_job_ready,
    output pidsc_pkg::t_job    o_job
);
    import pidsc_pkg::*;

    logic                     r_valid;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [MEAS_W-1:0] r_meas;
    logic signed [ERR_W-1:0]  w_err;
    logic [ERR_W-1:0]         w_abs;
    logic [DB_W-1:0]          w_sq;
    logic                     w_near;
    logic                     w_load;

    assign i_sample.ready = !r_valid || i_job_ready;
    assign w_load = i_sample.valid && i_sample.ready;

    // error = 8 * target - measurement
    assign w_err = $signed({{2{i_sample.target_angle[TGT_W-1]}}, i_sample.target_angle, 3'b000})
                 - $signed({{(ERR_W-MEAS_W){i_sample.measured_angle[MEAS_W-1]}},
                            i_sample.measured_angle});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_job_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_err  <= w_err;
            r_meas <= i_sample.measured_angle;
        end
    end

    // a magnitude of 256 or more squares past any deadband value
    assign w_abs  = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);
    assign w_near = (w_abs[ERR_W-1:8] == '0);
    assign w_sq   = DB_W'(w_abs[7:0]) * DB_W'(w_abs[7:0]);

    assign o_job_valid = r_valid;
    assign o_job.err   = r_err;
    assign o_job.meas  = r_meas;
    assign o_job.dead  = w_near && (w_sq < i_deadband_sq);

endmodule

FILE: hdl/pidsc_fifo.sv
// pidsc_fifo: short job queue between the front and the back
// depends on pidsc_pkg

module pidsc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  pidsc_pkg::t_job i_job,
    output logic            o_valid,
    input  logic            i_ready,
    output pidsc_pkg::t_job o_job
);
    import pidsc_pkg::*;

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_CW-1:0] r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_ready = (r_cnt != FIFO_CW'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

FILE: hdl/pidsc_back.sv
// pidsc_back: sequencer that updates the loop state and forms p, i and d terms
// on one shared multiplier, then clamps the drive; depends on pidsc_pkg and pidsc_if

module pidsc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pidsc_pkg::t_cfg     i_cfg,
    input  logic                i_job_valid,
    output logic                o_job_ready,
    input  pidsc_pkg::t_job     i_job,
    pidsc_result_if.source      o_result,
    output pidsc_pkg::t_back_stat o_stat
);
    import pidsc_pkg::*;

    t_back_state r_state;
    t_back_state n_state;
    t_term       r_term;

    logic signed [ERR_W-1:0]   r_err;
    logic signed [MEAS_W-1:0]  r_meas;
    logic                      r_dead;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [MEAS_W-1:0]  r_last;
    logic signed [DMEAS_W-1:0] r_dmeas;
    logic [PROD_W-1:0]         r_prod;
    logic                      r_neg;
    logic [Q_W-1:0]            r_q;
    logic signed [ACC_W-1:0]   r_acc;

    logic                      r_out_valid;
    logic [SERVO_W-1:0]        r_servo;
    logic                      r_out_dead;

    logic                      w_pop;
    logic                      w_out_free;
    logic                      w_out_load;
    logic signed [ISUM_W-1:0]  w_isum;
    logic signed [ISUM_W-1:0]  w_iclamp;
    logic [GAIN_W-1:0]         w_gain;
    logic signed [ERR_W-1:0]   w_val;
    logic                      w_flip;
    logic [ERR_W-1:0]          w_abs;
    logic [FULL_W-1:0]         w_full;
    logic signed [ACC_W-1:0]   w_term;
    logic signed [ACC_W-1:0]   w_drive;

    assign w_out_free = !r_out_valid || o_result.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = i_job.dead ? ST_OUT : ST_UPD;
                end
            end
            ST_UPD: n_state = ST_MUL;
            ST_MUL: n_state = ST_DIV;
            ST_DIV: n_state = ST_ACC;
            ST_ACC: n_state = (r_term == TERM_D) ? ST_OUT : ST_MUL;
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_pop         = 1'b0;
        w_out_load    = 1'b0;
        o_stat.idle   = 1'b0;
        o_stat.in_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_pop       = i_job_valid;
                o_stat.idle = 1'b1;
            end
            ST_OUT: begin
                w_out_load    = w_out_free;
                o_stat.in_out = 1'b1;
            end
            default: begin
                w_pop = 1'b0;
            end
        endcase
    end

    assign o_job_ready = w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // integral update with clamp, high limit wins when crossed
    assign w_isum = $signed({{(ISUM_W-INTEG_W){r_integ[INTEG_W-1]}}, r_integ})
                  + $signed({r_err[ERR_W-1], r_err});
    always_comb begin
        w_iclamp = w_isum;
        if (w_iclamp < $signed({{(ISUM_W-LIM_W){i_cfg.limit_low[LIM_W-1]}}, i_cfg.limit_low})) begin
            w_iclamp = $signed({{(ISUM_W-LIM_W){i_cfg.limit_low[LIM_W-1]}}, i_cfg.limit_low});
        end
        if (w_iclamp > $signed({{(ISUM_W-LIMH_W){1'b0}}, i_cfg.limit_high})) begin
            w_iclamp = $signed({{(ISUM_W-LIMH_W){1'b0}}, i_cfg.limit_high});
        end
    end

    // operand select for the current term
    always_comb begin
        w_gain = i_cfg.prop_gain;
        w_val  = r_err;
        w_flip = 1'b0;
        case (r_term)
            TERM_P: begin
                w_gain = i_cfg.prop_gain;
                w_val  = r_err;
            end
            TERM_I: begin
                w_gain = i_cfg.integ_gain;
                w_val  = $signed({{(ERR_W-INTEG_W){r_integ[INTEG_W-1]}}, r_integ});
            end
            TERM_D: begin
                w_gain = i_cfg.deriv_gain;
                w_val  = $signed({{(ERR_W-DMEAS_W){r_dmeas[DMEAS_W-1]}}, r_dmeas});
                w_flip = 1'b1;
            end
            default: begin
                w_flip = 1'b0;
            end
        endcase
    end

    assign w_abs  = w_val[ERR_W-1] ? ERR_W'(-w_val) : ERR_W'(w_val);
    assign w_full = FULL_W'(r_prod[PROD_W-1:PRE_SHIFT]) * FULL_W'(DIV_RECIP);
    assign w_term = r_neg ? -$signed({{(ACC_W-Q_W){1'b0}}, r_q})
                          :  $signed({{(ACC_W-Q_W){1'b0}}, r_q});

    // drive clamp
    always_comb begin
        w_drive = r_acc;
        if (w_drive < $signed({{(ACC_W-LIM_W){i_cfg.limit_low[LIM_W-1]}}, i_cfg.limit_low})) begin
            w_drive = $signed({{(ACC_W-LIM_W){i_cfg.limit_low[LIM_W-1]}}, i_cfg.limit_low});
        end
        if (w_drive > $signed({{(ACC_W-LIMH_W){1'b0}}, i_cfg.limit_high})) begin
            w_drive = $signed({{(ACC_W-LIMH_W){1'b0}}, i_cfg.limit_high});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_last  <= '0;
            r_term  <= TERM_P;
        end else begin
            if (r_state == ST_UPD) begin
                r_integ <= w_iclamp[INTEG_W-1:0];
                r_last  <= r_meas;
                r_term  <= TERM_P;
            end else if (r_state == ST_ACC) begin
                case (r_term)
                    TERM_P:  r_term <= TERM_I;
                    TERM_I:  r_term <= TERM_D;
                    default: r_term <= TERM_P;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_err  <= i_job.err;
            r_meas <= i_job.meas;
            r_dead <= i_job.dead;
        end
        case (r_state)
            ST_UPD: begin
                r_dmeas <= $signed({r_meas[MEAS_W-1], r_meas}) - $signed({r_last[MEAS_W-1], r_last});
                r_acc   <= '0;
            end
            ST_MUL: begin
                r_prod <= PROD_W'(w_gain) * PROD_W'(w_abs[MAG_W-1:0]);
                r_neg  <= w_val[ERR_W-1] ^ w_flip;
            end
            ST_DIV: begin
                r_q <= w_full[FULL_W-1:DIV_SHIFT];
            end
            ST_ACC: begin
                r_acc <= r_acc + w_term;
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_servo    <= r_dead ? NEUTRAL_POS : NEUTRAL_POS - w_drive[SERVO_W-1:0];
            r_out_dead <= r_dead;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.servo_position = r_servo;
    assign o_result.in_deadband    = r_out_dead;

endmodule
